### sv/gcll_pkg.sv
package gcll_pkg;

  // Command codes carried by an input beat
  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_LOOKUP = 2'd2
  } cmd_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_CODE_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_GLYPH_BYTES = 2'd1;
  localparam logic [1:0] CFG_BITMAP_BASE = 2'd2;

  localparam logic [2:0]  CODE_WIDTH_RST  = 3'd1;
  localparam logic [7:0]  GLYPH_BYTES_RST = 8'd32;
  localparam logic [31:0] BITMAP_BASE_RST = 32'h0000_0000;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] code_value;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [7:0]  glyph_index;
    logic [31:0] glyph_address;
  } out_item_t;

  // Search token handed from cell to cell
  typedef struct packed {
    logic        valid;
    logic        found;
    logic [31:0] key;
    logic [31:0] addr;
  } tok_t;

endpackage

### sv/gcll_cell.sv
module gcll_cell #(
  parameter int IDX_W = 8,
  parameter int CNT_W = 9
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [31:0]        wr_data,
  input  logic [31:0]        mask,
  input  logic [7:0]         glyph_bytes,
  input  gcll_pkg::tok_t     tok_in,
  input  logic [IDX_W-1:0]   idx_in,
  input  logic [CNT_W-1:0]   remain_in,
  output gcll_pkg::tok_t     tok_out,
  output logic [IDX_W-1:0]   idx_out,
  output logic [CNT_W-1:0]   remain_out
);
  import gcll_pkg::*;

  logic [31:0]      entry_r;
  logic             valid_r, valid_nxt;
  tok_t             tok_r, tok_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] remain_r, remain_nxt;
  logic             active, hit, done;

  // Hold the stored code; only the matching append writes it
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r <= wr_data;
    end
  end

  always_comb begin
    active     = tok_in.valid && !tok_in.found && (remain_in != '0);
    hit        = active && ((entry_r & mask) == tok_in.key);
    done       = tok_in.found || hit;
    valid_nxt  = tok_in.valid;
    tok_nxt    = tok_in;
    tok_nxt.found = done;
    // Freeze address and index once matched, otherwise step one glyph on
    tok_nxt.addr  = done ? tok_in.addr : tok_in.addr + {24'd0, glyph_bytes};
    idx_nxt    = done ? idx_in : idx_in + IDX_W'(1);
    remain_nxt = (remain_in == '0) ? '0 : remain_in - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tok_r    <= tok_nxt;
    idx_r    <= idx_nxt;
    remain_r <= remain_nxt;
  end

  always_comb begin
    tok_out       = tok_r;
    tok_out.valid = valid_r;
  end

  assign idx_out    = idx_r;
  assign remain_out = remain_r;

endmodule

### sv/glyph_code_linear_lookup.sv
// Clear and append: taken while not busy; the next command may follow at once.
// Lookup: the search token walks the whole cell row one cell per cycle, with
//   the result strobe registered after the last cell, and busy stays high
//   until its result beat.
// Result beats cannot be held off by the receiver.
// Reset (synchronous, rst_n low): table empty, registers to their defaults.
module glyph_code_linear_lookup #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  gcll_pkg::in_item_t  in_data,
  output logic                out_valid,
  output gcll_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import gcll_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  // Configuration registers
  logic [2:0]  code_width_r;
  logic [7:0]  glyph_bytes_r;
  logic [31:0] bitmap_base_r;

  // Control state
  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic        accept, do_clear, do_append, do_lookup, room;
  logic [31:0] mask;

  // Token chain: slot 0 is the launch, slot i+1 the output of cell i
  tok_t             tok    [0:TABLE_DEPTH];
  logic [IDX_W-1:0] idx    [0:TABLE_DEPTH];
  logic [CNT_W-1:0] remain [0:TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] wr_en;
  logic [TABLE_DEPTH-1:0] tok_valid_vec;
  logic [IDX_W+7:0]       idx_wide;

  assign accept    = start && !busy_r;
  assign do_clear  = accept && (cmd_e'(in_data.command) == CMD_CLEAR);
  assign do_append = accept && (cmd_e'(in_data.command) == CMD_APPEND);
  assign do_lookup = accept && (cmd_e'(in_data.command) == CMD_LOOKUP);
  assign room      = (count_r < CNT_W'(TABLE_DEPTH));

  // Compare mask from the code width; other settings act as one byte
  always_comb begin
    unique case (code_width_r)
      3'd2:    mask = 32'h0000_FFFF;
      3'd3:    mask = 32'h00FF_FFFF;
      3'd4:    mask = 32'hFFFF_FFFF;
      default: mask = 32'h0000_00FF;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_width_r  <= CODE_WIDTH_RST;
      glyph_bytes_r <= GLYPH_BYTES_RST;
      bitmap_base_r <= BITMAP_BASE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CODE_WIDTH:  code_width_r  <= cfg_data[2:0];
        CFG_GLYPH_BYTES: glyph_bytes_r <= cfg_data[7:0];
        CFG_BITMAP_BASE: bitmap_base_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Launch token: masked key, base address, index zero, entries to visit
  always_comb begin
    tok[0].valid = do_lookup;
    tok[0].found = 1'b0;
    tok[0].key   = in_data.code_value & mask;
    tok[0].addr  = bitmap_base_r;
    idx[0]       = '0;
    remain[0]    = count_r;
  end

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      // Write the append into the cell at the fill position
      assign wr_en[gi]         = do_append && (count_r == CNT_W'(gi));
      assign tok_valid_vec[gi] = tok[gi+1].valid;

      gcll_cell #(
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
      ) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (wr_en[gi]),
        .wr_data     (in_data.code_value),
        .mask        (mask),
        .glyph_bytes (glyph_bytes_r),
        .tok_in      (tok[gi]),
        .idx_in      (idx[gi]),
        .remain_in   (remain[gi]),
        .tok_out     (tok[gi+1]),
        .idx_out     (idx[gi+1]),
        .remain_out  (remain[gi+1])
      );
    end
  endgenerate

  // Fill count: clear empties it; drop appends to a full table
  always_comb begin
    count_nxt = count_r;
    if (do_clear) begin
      count_nxt = '0;
    end else if (do_append && room) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  // Busy from lookup launch until the token leaves the last cell
  always_comb begin
    busy_nxt = busy_r;
    if (do_lookup) begin
      busy_nxt = 1'b1;
    end else if (tok[TABLE_DEPTH].valid) begin
      busy_nxt = 1'b0;
    end
  end

  // Result beat: zero index and address on a miss
  assign idx_wide = {8'd0, idx[TABLE_DEPTH]};

  always_comb begin
    out_valid_nxt              = tok[TABLE_DEPTH].valid;
    out_data_nxt.found         = tok[TABLE_DEPTH].found;
    out_data_nxt.glyph_index   = tok[TABLE_DEPTH].found ? idx_wide[7:0] : 8'd0;
    out_data_nxt.glyph_address = tok[TABLE_DEPTH].found ? tok[TABLE_DEPTH].addr : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // At most one search token in the row
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_valid_vec))
    else $error("more than one search token in the cell row");

  // No token in flight while idle
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (tok_valid_vec == '0))
    else $error("search token present while not busy");

  // A result beat ends the busy period
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy_r)
    else $error("result issued while still busy");

  // A lookup launch raises busy
  a_launch_busy: assert property (@(posedge clk) disable iff (!rst_n)
    do_lookup |=> busy_r)
    else $error("lookup accepted without going busy");

  // Fill count never exceeds the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

endmodule
